FILE: rtl/core/multiple_flow_direction_core_assert.svh
// assertion macros used by the checker file
// no dependencies
`ifndef MULTIPLE_FLOW_DIRECTION_CORE_ASSERT_SVH
`define MULTIPLE_FLOW_DIRECTION_CORE_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define MFD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MFD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mfd_pkg.sv
// types and constants for the multiple flow direction core
// no dependencies
package mfd_pkg;
    localparam int HEIGHT_BITS = 24;
    localparam int FRAC_BITS   = 16;
    localparam int DIRS        = 8;
    localparam int LEN_BITS    = 17;
    localparam int SLOPE_BITS  = HEIGHT_BITS + LEN_BITS;
    localparam int SUM_BITS    = SLOPE_BITS + 3;
    localparam int FOUT_BITS   = FRAC_BITS + 1;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 17;

    localparam logic [CFG_IDX_BITS-1:0] REG_FLAT_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_INV_AXIAL      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_INV_DIAGONAL   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIAGONAL_MASK  = 2'd3;

    localparam logic [3:0] DIR_NONE = 4'hF;

    typedef logic [HEIGHT_BITS-1:0] height_t;
    typedef logic [SLOPE_BITS-1:0]  slope_t;
    typedef logic [SUM_BITS-1:0]    sum_t;
    typedef logic [FOUT_BITS-1:0]   frac_t;

    typedef struct packed {
        logic [15:0]         flat_threshold;
        logic [LEN_BITS-1:0] inv_axial_length;
        logic [LEN_BITS-1:0] inv_diagonal_length;
        logic [DIRS-1:0]     diagonal_mask;
    } cfg_t;

    typedef struct packed {
        height_t             center_height;
        height_t [DIRS-1:0]  nb_height;
        logic [DIRS-1:0]     inside_mask;
    } cell_t;

    typedef struct packed {
        logic [DIRS-1:0]     downhill_mask;
        logic [3:0]          downhill_count;
        logic [3:0]          steepest_dir;
        frac_t [DIRS-1:0]    frac;
    } flow_t;
endpackage

FILE: rtl/core/mfd_stream_if.sv
// valid/ready stream interface carrying one payload type
// depends on nothing; payload type given by the instantiating scope
interface mfd_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/mfd_divider.sv
// pipelined restoring divider: one quotient bit per stage, FOUT_BITS stages
// depends on mfd_pkg; carries flow_t side data through the stages
module mfd_divider (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  mfd_pkg::slope_t [mfd_pkg::DIRS-1:0] in_num,
    input  mfd_pkg::sum_t         in_den,
    input  mfd_pkg::flow_t        in_side,
    output logic                  out_valid,
    output mfd_pkg::flow_t        out_flow
);
    import mfd_pkg::*;
    localparam int ST = FOUT_BITS;

    logic [ST:1]                  v_reg;
    sum_t [ST-1:1][DIRS-1:0]      rem_reg;
    frac_t [ST:1][DIRS-1:0]       q_reg;
    sum_t [ST:1]                  den_reg;
    flow_t [ST:1]                 side_reg;

    for (genvar s = 0; s < ST; s++) begin : g_stage
        logic                        v_cur;
        sum_t [DIRS-1:0]             r_cur;
        frac_t [DIRS-1:0]            q_cur;
        sum_t                        den_cur;
        flow_t                       side_cur;
        logic [DIRS-1:0][SUM_BITS:0] t;
        logic [DIRS-1:0]             ge;
        frac_t [DIRS-1:0]            q_next;

        if (s == 0) begin : g_src
            always_comb
            begin
                v_cur    = in_valid;
                den_cur  = in_den;
                side_cur = in_side;
                for (int d = 0; d < DIRS; d++)
                begin
                    r_cur[d] = sum_t'(in_num[d]);
                    q_cur[d] = '0;
                end
            end
        end
        else begin : g_src
            always_comb
            begin
                v_cur    = v_reg[s];
                r_cur    = rem_reg[s];
                q_cur    = q_reg[s];
                den_cur  = den_reg[s];
                side_cur = side_reg[s];
            end
        end

        always_comb
        begin
            for (int d = 0; d < DIRS; d++)
            begin
                // first stage compares unshifted (quotient bit FRAC_BITS)
                t[d] = (s == 0) ? {1'b0, r_cur[d]} : {r_cur[d], 1'b0};
                ge[d] = (t[d] >= {1'b0, den_cur});
                q_next[d] = {q_cur[d][FOUT_BITS-2:0], ge[d]};
            end
        end

        // the last stage needs no remainder
        if (s < ST - 1) begin : g_rem
            sum_t [DIRS-1:0] r_next;
            always_comb
            begin
                for (int d = 0; d < DIRS; d++)
                    r_next[d] = ge[d] ? sum_t'(t[d] - {1'b0, den_cur}) : sum_t'(t[d]);
            end
            always_ff @(posedge clk)
            begin
                if (en)
                    rem_reg[s+1] <= r_next;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s+1] <= 1'b0;
            else if (en)
                v_reg[s+1] <= v_cur;
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[s+1]    <= q_next;
                den_reg[s+1]  <= den_cur;
                side_reg[s+1] <= side_cur;
            end
        end
    end

    always_comb
    begin
        out_valid = v_reg[ST];
        out_flow  = side_reg[ST];
        for (int d = 0; d < DIRS; d++)
            out_flow.frac[d] = (side_reg[ST].downhill_mask[d] && den_reg[ST] != '0)
                             ? q_reg[ST][d] : '0;
    end
endmodule

FILE: rtl/core/multiple_flow_direction_core.sv
// multiple flow direction routing for one terrain cell per transfer
// depends on mfd_pkg, mfd_stream_if and mfd_divider
//
// usage:
//   site: sink channel with the centre height, eight neighbour heights and
//   the inside mask; flow: source channel with downhill mask, count,
//   steepest direction and eight Q1.16 fractions.
//   cfg_*: write port, index 0..3 as flat threshold, inverse axial length,
//   inverse diagonal length, diagonal mask; write only while idle.
//   throughput: one cell per cycle sustained while flow is not stalled.
//   pipeline: 21 register stages: drop, multiply, pair sums, total sum
//   and best pick, then 17 divider stages one quotient bit each.
//   the whole pipeline advances together; when flow is stalled with a
//   result waiting, site ready drops and every stage holds.
//   reset clears all valid bits and loads the register reset values.
module multiple_flow_direction_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mfd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [mfd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    mfd_stream_if.sink                         site,
    mfd_stream_if.source                       flow
);
    import mfd_pkg::*;

    cfg_t cfg_reg;
    logic en;
    assign en = !flow.valid || flow.ready;
    assign site.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flat_threshold      <= 16'd1;
            cfg_reg.inv_axial_length    <= 17'd65536;
            cfg_reg.inv_diagonal_length <= 17'd46341;
            cfg_reg.diagonal_mask       <= 8'd170;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FLAT_THRESHOLD: cfg_reg.flat_threshold <= cfg_data[15:0];
                REG_INV_AXIAL:      cfg_reg.inv_axial_length <= cfg_data;
                REG_INV_DIAGONAL:   cfg_reg.inv_diagonal_length <= cfg_data;
                REG_DIAGONAL_MASK:  cfg_reg.diagonal_mask <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // stage 1: drops and downhill test
    logic s1_v_reg;
    logic [DIRS-1:0] s1_mask_reg;
    height_t [DIRS-1:0] s1_drop_reg;
    logic [DIRS-1:0] dn_next;
    height_t [DIRS-1:0] drop_next;
    always_comb
    begin
        for (int d = 0; d < DIRS; d++)
        begin
            drop_next[d] = site.data.center_height - site.data.nb_height[d];
            dn_next[d] = site.data.inside_mask[d]
                && (site.data.nb_height[d] < site.data.center_height)
                && (drop_next[d] > height_t'(cfg_reg.flat_threshold));
        end
    end

    // stage 2: slopes
    logic s2_v_reg;
    logic [DIRS-1:0] s2_mask_reg;
    slope_t [DIRS-1:0] s2_slope_reg;
    slope_t [DIRS-1:0] slope_next;
    always_comb
    begin
        for (int d = 0; d < DIRS; d++)
            slope_next[d] = s1_mask_reg[d]
                ? slope_t'(s1_drop_reg[d]) * slope_t'(cfg_reg.diagonal_mask[d]
                    ? cfg_reg.inv_diagonal_length : cfg_reg.inv_axial_length)
                : '0;
    end

    // stage 3: pair sums and pair winners
    logic s3_v_reg;
    logic [DIRS-1:0] s3_mask_reg;
    slope_t [DIRS-1:0] s3_slope_reg;
    sum_t [3:0] s3_psum_reg;
    logic [3:0][2:0] s3_pdir_reg;
    logic [3:0] s3_pany_reg;
    sum_t [3:0] psum_next;
    logic [3:0][2:0] pdir_next;
    logic [3:0] pany_next;
    always_comb
    begin
        for (int p = 0; p < 4; p++)
        begin
            psum_next[p] = sum_t'(s2_slope_reg[2*p]) + sum_t'(s2_slope_reg[2*p+1]);
            pany_next[p] = s2_mask_reg[2*p] || s2_mask_reg[2*p+1];
            if (!s2_mask_reg[2*p]
                || (s2_mask_reg[2*p+1] && s2_slope_reg[2*p+1] > s2_slope_reg[2*p]))
                pdir_next[p] = 3'(2*p+1);
            else
                pdir_next[p] = 3'(2*p);
        end
    end

    // stage 4: total sum, steepest, count
    logic s4_v_reg;
    slope_t [DIRS-1:0] s4_slope_reg;
    sum_t s4_sum_reg;
    flow_t s4_side_reg;
    flow_t side_next;
    logic [2:0] best;
    logic any;
    always_comb
    begin
        any = 1'b0;
        best = '0;
        for (int p = 0; p < 4; p++)
            if (s3_pany_reg[p] && (!any
                || s3_slope_reg[s3_pdir_reg[p]] > s3_slope_reg[best]))
            begin
                best = s3_pdir_reg[p];
                any = 1'b1;
            end
        side_next.downhill_mask  = s3_mask_reg;
        side_next.downhill_count = 4'($countones(s3_mask_reg));
        side_next.steepest_dir   = any ? {1'b0, best} : DIR_NONE;
        side_next.frac           = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= site.valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mask_reg  <= dn_next;
            s1_drop_reg  <= drop_next;
            s2_mask_reg  <= s1_mask_reg;
            s2_slope_reg <= slope_next;
            s3_mask_reg  <= s2_mask_reg;
            s3_slope_reg <= s2_slope_reg;
            s3_psum_reg  <= psum_next;
            s3_pdir_reg  <= pdir_next;
            s3_pany_reg  <= pany_next;
            s4_slope_reg <= s3_slope_reg;
            s4_sum_reg   <= (s3_psum_reg[0] + s3_psum_reg[1])
                          + (s3_psum_reg[2] + s3_psum_reg[3]);
            s4_side_reg  <= side_next;
        end
    end

    mfd_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s4_v_reg),
        .in_num    (s4_slope_reg),
        .in_den    (s4_sum_reg),
        .in_side   (s4_side_reg),
        .out_valid (flow.valid),
        .out_flow  (flow.data)
    );
endmodule

FILE: rtl/core/mfd_checker.sv
// port-level checks for the multiple flow direction core
// depends on mfd_pkg and multiple_flow_direction_core_assert.svh
`include "multiple_flow_direction_core_assert.svh"
module mfd_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 site_ready,
    input logic                 flow_valid,
    input logic                 flow_ready,
    input mfd_pkg::flow_t       flow_data
);
    import mfd_pkg::*;
    `MFD_ASSERT_IMP(a_count, clk, rst_n, flow_valid,
        flow_data.downhill_count == 4'($countones(flow_data.downhill_mask)),
        "count does not match mask")
    `MFD_ASSERT_IMP(a_none, clk, rst_n, flow_valid && flow_data.downhill_mask == '0,
        flow_data.steepest_dir == DIR_NONE, "steepest set without downhill")
    `MFD_ASSERT_IMP(a_stall, clk, rst_n, flow_valid && !flow_ready, !site_ready,
        "input taken while output stalled")
    `MFD_ASSERT_NXT(a_hold, clk, rst_n, flow_valid && !flow_ready,
        flow_valid && $stable(flow_data), "stalled result changed")
endmodule

bind multiple_flow_direction_core mfd_checker u_mfd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .site_ready (site.ready),
    .flow_valid (flow.valid),
    .flow_ready (flow.ready),
    .flow_data  (flow.data)
);

FILE: bench/tb_multiple_flow_direction_core.sv
// testbench for the multiple flow direction core: directed and random cells
// checked against a local flow predictor; depends on mfd_pkg, mfd_stream_if and the core
`timescale 1ns / 100ps

module tb_multiple_flow_direction_core;
    import mfd_pkg::*;

    localparam int LATENCY = 22;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    mfd_stream_if #(.payload_t(cell_t)) site ();
    mfd_stream_if #(.payload_t(flow_t)) flow ();

    multiple_flow_direction_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .site(site.sink), .flow(flow.source)
    );

    always #5 clk = ~clk;

    cfg_t   model_cfg;
    flow_t  expected_flows[$];
    int     errors = 0;
    longint cycles = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     hold_off_cycles = 0;

    initial
    begin
        site.valid = 1'b0;
        site.data = '0;
        flow.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // floor(num * 2^FRAC_BITS / den), num <= den
    function automatic frac_t share(sum_t num, sum_t den);
        logic [SUM_BITS:0] r;
        frac_t q;
        r = {1'b0, num};
        q = '0;
        if (r >= {1'b0, den})
        begin
            r = r - {1'b0, den};
            q = frac_t'(1);
        end
        for (int k = 0; k < FRAC_BITS; k++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= {1'b0, den})
            begin
                r = r - {1'b0, den};
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic flow_t route_flow(cell_t c, cfg_t g);
        flow_t f;
        slope_t slope[DIRS];
        sum_t total;
        int best;
        height_t drop;
        logic [LEN_BITS-1:0] inv;
        f = '0;
        total = '0;
        best = -1;
        for (int d = 0; d < DIRS; d++)
        begin
            slope[d] = '0;
            if (c.inside_mask[d] && c.nb_height[d] < c.center_height)
            begin
                drop = c.center_height - c.nb_height[d];
                inv = g.diagonal_mask[d] ? g.inv_diagonal_length : g.inv_axial_length;
                if (drop > g.flat_threshold)
                begin
                    slope[d] = slope_t'(drop) * slope_t'(inv);
                    total = total + sum_t'(slope[d]);
                    f.downhill_mask[d] = 1'b1;
                    f.downhill_count = 4'(f.downhill_count + 4'd1);
                    if (best < 0 || slope[d] > slope[best])
                        best = d;
                end
            end
        end
        f.steepest_dir = (best < 0) ? DIR_NONE : 4'(best);
        for (int d = 0; d < DIRS; d++)
            if (f.downhill_mask[d] && total != 0)
                f.frac[d] = share(sum_t'(slope[d]), total);
        return f;
    endfunction

    // receiver: random stalls plus an optional long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            flow.ready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            flow.ready <= 1'b0;
        end
        else
            flow.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        flow_t exp_f;
        if (rst_n && flow.valid && flow.ready)
        begin
            if (expected_flows.size() == 0)
            begin
                $error("flow transfer with nothing expected");
                errors++;
            end
            else
            begin
                exp_f = expected_flows.pop_front();
                if (flow.data.downhill_mask !== exp_f.downhill_mask)
                begin
                    $error("downhill_mask exp %h got %h", exp_f.downhill_mask,
                           flow.data.downhill_mask);
                    errors++;
                end
                if (flow.data.downhill_count !== exp_f.downhill_count)
                begin
                    $error("downhill_count exp %0d got %0d", exp_f.downhill_count,
                           flow.data.downhill_count);
                    errors++;
                end
                if (flow.data.steepest_dir !== exp_f.steepest_dir)
                begin
                    $error("steepest_dir exp %h got %h", exp_f.steepest_dir,
                           flow.data.steepest_dir);
                    errors++;
                end
                for (int d = 0; d < DIRS; d++)
                    if (flow.data.frac[d] !== exp_f.frac[d])
                    begin
                        $error("frac_%0d exp %h got %h", d, exp_f.frac[d],
                               flow.data.frac[d]);
                        errors++;
                    end
            end
        end
    end

    task automatic send_cell(cell_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            site.valid <= 1'b0;
            @(posedge clk);
        end
        site.valid <= 1'b1;
        site.data <= c;
        @(posedge clk);
        while (!site.ready)
            @(posedge clk);
        expected_flows.push_back(route_flow(c, model_cfg));
    endtask

    task automatic drain_flows();
        site.valid <= 1'b0;
        while (expected_flows.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FLAT_THRESHOLD: model_cfg.flat_threshold = val[15:0];
            REG_INV_AXIAL:      model_cfg.inv_axial_length = val;
            REG_INV_DIAGONAL:   model_cfg.inv_diagonal_length = val;
            REG_DIAGONAL_MASK:  model_cfg.diagonal_mask = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [15:0] th, logic [16:0] ax, logic [16:0] dg,
                              logic [7:0] dm);
        write_reg(REG_FLAT_THRESHOLD, 17'(th));
        write_reg(REG_INV_AXIAL, ax);
        write_reg(REG_INV_DIAGONAL, dg);
        write_reg(REG_DIAGONAL_MASK, 17'(dm));
    endtask

    function automatic cell_t random_cell();
        cell_t c;
        height_t spread;
        c.center_height = height_t'($urandom);
        c.inside_mask = 8'($urandom);
        // mostly heights close to the centre so threshold and ties matter
        spread = height_t'(1) << $urandom_range(HEIGHT_BITS - 1);
        for (int d = 0; d < DIRS; d++)
        begin
            case ($urandom_range(5))
                0: c.nb_height[d] = height_t'($urandom);
                1: c.nb_height[d] = c.center_height;
                2: c.nb_height[d] = c.center_height - height_t'(model_cfg.flat_threshold)
                                    - height_t'($urandom_range(2)) + height_t'(1);
                default: c.nb_height[d] = c.center_height
                                          - height_t'($urandom % spread);
            endcase
        end
        if ($urandom_range(9) == 0)
            c.inside_mask = 8'hFF;
        return c;
    endfunction

    task automatic test_directed();
        cell_t c;
        // flat cell, no downhill neighbour
        c.center_height = 24'd1000;
        c.nb_height = {8{24'd1000}};
        c.inside_mask = 8'hFF;
        send_cell(c);
        // highest peak: full drop in every direction
        c.center_height = '1;
        c.nb_height = '0;
        send_cell(c);
        // all outside the grid
        c.inside_mask = 8'h00;
        send_cell(c);
        // single downhill direction each way
        for (int d = 0; d < DIRS; d++)
        begin
            c.center_height = 24'd500;
            c.nb_height = {8{24'd600}};
            c.nb_height[d] = 24'd10;
            c.inside_mask = 8'hFF;
            send_cell(c);
        end
        // drop exactly at threshold and one above
        c.center_height = 24'd100;
        c.nb_height = {8{24'd99}};
        c.nb_height[3] = 24'd98;
        send_cell(c);
        // ties between equal slopes
        c.nb_height = {8{24'd50}};
        send_cell(c);
        c.center_height = '1;
        c.nb_height = {24'd0, 24'hFFFFFE, 24'd0, 24'd5, 24'd1, 24'd0, 24'd7, 24'hFFFFFF};
        c.inside_mask = 8'b1011_0110;
        send_cell(c);
        drain_flows();
        // zero inverse lengths give zero slope sum
        set_config(16'd0, 17'd0, 17'd0, 8'h55);
        c.center_height = 24'd300;
        c.nb_height = {8{24'd100}};
        c.inside_mask = 8'hFF;
        send_cell(c);
        c.nb_height[0] = 24'd299;
        send_cell(c);
        drain_flows();
        set_config(16'hFFFF, 17'd65536, 17'd1, 8'hFF);
        c.center_height = '1;
        c.nb_height = {24'd0, 24'h00FFFF, 24'h010000, 24'hFF0000, 24'd0, 24'd1, 24'd2, 24'd3};
        send_cell(c);
        c.nb_height = '0;
        send_cell(c);
        drain_flows();
    endtask

    task automatic test_random(int n, int sidle, int ridle);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        for (int i = 0; i < n; i++)
            send_cell(random_cell());
        drain_flows();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_cycles = 200;
        for (int i = 0; i < 60; i++)
            send_cell(random_cell());
        site.valid <= 1'b0;
        while (expected_flows.size() != 0)
            @(posedge clk);
        for (int i = 0; i < 10; i++)
            send_cell(random_cell());
        drain_flows();
    endtask

    initial
    begin
        model_cfg.flat_threshold = 16'd1;
        model_cfg.inv_axial_length = 17'd65536;
        model_cfg.inv_diagonal_length = 17'd46341;
        model_cfg.diagonal_mask = 8'd170;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        set_config(16'd1, 17'd65536, 17'd46341, 8'd170);
        test_random(70, 17, 53);
        set_config(16'd0, 17'd1, 17'd65536, 8'h0F);
        test_random(70, 53, 17);
        set_config(16'($urandom), 17'($urandom_range(65536)),
                   17'($urandom_range(65536)), 8'($urandom));
        test_random(70, 0, 0);
        set_config(16'hFFFF, 17'd65536, 17'd65536, 8'h00);
        test_random(60, 17, 53);
        set_config(16'd3, 17'd12345, 17'd0, 8'hFF);
        test_random(60, 53, 17);
        set_config(16'd1, 17'd65536, 17'd46341, 8'd170);
        test_backpressure();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
